>>> rtl/ust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ust_pkg: shared types and constants of the integer set table
// Operation and status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package ust_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int INDEX_W      = 6;
	localparam int COUNT_W      = 7;

	typedef enum logic [2:0] {
		FN_ADD    = 3'd0,
		FN_REMOVE = 3'd1,
		FN_QUERY  = 3'd2,
		FN_READ   = 3'd3,
		FN_CLEAR  = 3'd4
	} ust_func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_PRESENT = 3'd1,
		ST_ABSENT  = 3'd2,
		ST_FULL    = 3'd3,
		ST_RANGE   = 3'd4
	} ust_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_USE,
		S_DONE
	} ust_state_t;

	typedef struct packed {
		logic [2:0]                status;
		logic                      found;
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]        count;
	} ust_res_t;

endpackage

>>> rtl/unordered_int_set_table_unit.sv
`timescale 1ns / 1ps
// Add, remove and query search the stored entries in turn before the result beat; a
// remove that moves the last entry then fetches it and writes it into the hole. A read
// fetches its entry, or goes straight to the result out of range, as clear does.
// One item at a time; the search reads one stored entry per cycle from the single RAM port.
// Reset: arst_n clears the count and the controller; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// unordered_int_set_table_unit: set of distinct 32-bit integers
// Unordered table with count, swap-remove, indexed read and clear, stream ports.
// ----------------------------------------------------------------------------
module unordered_int_set_table_unit #(
	parameter int CAPACITY = ust_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] value, [37:32] index, [39:38] zero
	input  logic [2:0]  s_axis_tuser,  // [2:0] func
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [0] found, [32:1] read_value, [39:33] count
	output logic [2:0]  m_axis_tuser   // [2:0] status
);
	import ust_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// engine <-> store
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic signed [VALUE_W-1:0] rd_data;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic signed [VALUE_W-1:0] wr_data;

	// engine <-> output register
	logic     res_valid;
	logic     res_ready;
	ust_res_t res;

	// result beat register: lets the engine take a new item while a result waits
	ust_res_t out_q;
	logic     out_valid_q;

	ust_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ust_engine #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_func  (s_axis_tuser),
		.req_value (s_axis_tdata[31:0]),
		.req_index (s_axis_tdata[37:32]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// the register is free when empty or being drained this cycle
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {out_q.count, out_q.read_value, out_q.found};

endmodule

>>> rtl/ust_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ust_mem: entry store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ust_mem #(
	parameter int DEPTH = ust_pkg::CAPACITY_DEF,
	parameter int AW    = ust_pkg::INDEX_W
) (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [AW-1:0]                       rd_addr,
	output logic signed [ust_pkg::VALUE_W-1:0]  rd_data,
	input  logic                                wr_en,
	input  logic [AW-1:0]                       wr_addr,
	input  logic signed [ust_pkg::VALUE_W-1:0]  wr_data
);
	import ust_pkg::*;

	logic signed [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/ust_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ust_engine: operation sequencer
// Linear search over the store, append, swap-remove, indexed read, clear.
// ----------------------------------------------------------------------------
module ust_engine #(
	parameter int CAPACITY = ust_pkg::CAPACITY_DEF,
	parameter int AW       = ust_pkg::INDEX_W,
	parameter int CW       = ust_pkg::COUNT_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request side
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          req_func,
	input  logic signed [ust_pkg::VALUE_W-1:0]  req_value,
	input  logic [ust_pkg::INDEX_W-1:0]         req_index,
	// result side
	output logic                                res_valid,
	input  logic                                res_ready,
	output ust_pkg::ust_res_t                   res,
	// store
	output logic                                rd_en,
	output logic [AW-1:0]                       rd_addr,
	input  logic signed [ust_pkg::VALUE_W-1:0]  rd_data,
	output logic                                wr_en,
	output logic [AW-1:0]                       wr_addr,
	output logic signed [ust_pkg::VALUE_W-1:0]  wr_data
);
	import ust_pkg::*;

	ust_state_t state_q, state_nxt;

	logic [2:0]                func_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [INDEX_W-1:0]        index_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             ptr_q;
	logic                      chk_s1;
	logic [AW-1:0]             pos_s1;
	logic [AW-1:0]             pos_q;
	logic [2:0]                status_q;
	logic                      found_q;
	logic signed [VALUE_W-1:0] rdval_q;

	logic issue;
	logic match;
	logic full;
	logic idx_ok;
	logic move_req;

	assign issue    = ptr_q < count_q;
	assign match    = chk_s1 && (rd_data == value_q);
	assign full     = count_q >= CW'(CAPACITY);
	assign idx_ok   = 32'(req_index) < 32'(count_q);
	// hole left below the new last slot needs the last entry moved in
	assign move_req = 32'(pos_s1) < 32'(count_q) - 32'd1;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_func)
						FN_ADD, FN_REMOVE, FN_QUERY: state_nxt = S_SCAN;
						FN_READ:                     state_nxt = idx_ok ? S_FETCH : S_DONE;
						default:                     state_nxt = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (match) begin
					state_nxt = (func_q == FN_REMOVE && move_req) ? S_FETCH : S_DONE;
				end else if (!issue) begin
					state_nxt = S_DONE;
				end
			end
			S_FETCH: state_nxt = S_USE;
			S_USE:   state_nxt = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs and store control
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = AW'(ptr_q);
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = rd_data;
		case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_SCAN: begin
				rd_en = issue;
				if (!match && !issue && func_q == FN_ADD && !full) begin
					wr_en   = 1'b1;
					wr_addr = AW'(count_q);
					wr_data = value_q;
				end
			end
			S_FETCH: begin
				rd_en   = 1'b1;
				// count is already decremented for remove: it addresses the last entry
				rd_addr = (func_q == FN_READ) ? AW'(index_q) : AW'(count_q);
			end
			S_USE:  wr_en = (func_q == FN_REMOVE);
			S_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res.status     = status_q;
	assign res.found      = found_q;
	assign res.read_value = rdval_q;
	assign res.count      = COUNT_W'(count_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			chk_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				S_IDLE: begin
					chk_s1 <= 1'b0;
					if (req_valid && req_func == FN_CLEAR) begin
						count_q <= '0;
					end
				end
				S_SCAN: begin
					chk_s1 <= issue && !match;
					if (match && func_q == FN_REMOVE) begin
						count_q <= count_q - 1'b1;
					end else if (!match && !issue && func_q == FN_ADD && !full) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q   <= req_func;
				value_q  <= req_value;
				index_q  <= req_index;
				ptr_q    <= '0;
				status_q <= ST_OK;
				found_q  <= 1'b0;
				rdval_q  <= '0;
				if (req_func == FN_READ && !idx_ok) begin
					status_q <= ST_RANGE;
				end
			end
			S_SCAN: begin
				pos_s1 <= AW'(ptr_q);
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (match) begin
					pos_q   <= pos_s1;
					found_q <= (func_q != FN_READ);
					if (func_q == FN_ADD) begin
						status_q <= ST_PRESENT;
					end
				end else if (!issue) begin
					case (func_q)
						FN_ADD:    status_q <= full ? ST_FULL : ST_OK;
						FN_REMOVE: status_q <= ST_ABSENT;
						FN_QUERY:  status_q <= ST_ABSENT;
						default:   status_q <= ST_OK;
					endcase
				end
			end
			S_USE: begin
				if (func_q == FN_READ) begin
					rdval_q <= rd_data;
				end
			end
			default: ;
		endcase
	end

	// the count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("entry count above capacity");

	// no store write while waiting for a request or holding a result
	a_wr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !wr_en)
		else $error("store write outside an operation");

	// a hit on remove drops the count by exactly one
	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && match && func_q == FN_REMOVE)
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not decrement the count");

	// a move always fills a slot below the shrunken count
	a_move_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_USE && func_q == FN_REMOVE) |-> (32'(pos_q) < 32'(count_q)))
		else $error("moved entry written outside the live range");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for unordered_int_set_table_unit
// Directed and random requests with bursty stalls on both streams. A small
// scoreboard mirrors the table, predicts every result beat and checks them
// in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import ust_pkg::*;

	localparam int CAP       = 64;
	localparam int N_ITEMS   = 1450;
	localparam int CALM_TAIL = 150;
	localparam int TAIL_CYC  = 80;
	localparam int LIMIT_NS  = 20_000_000;
	localparam int POOL_N    = 48;

	// func codes the block treats as no-ops
	localparam logic [2:0] SPARE_FN [3] = '{3'd5, 3'd6, 3'd7};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [31:0] value, [37:32] index, [39:38] zero
	logic [2:0]  s_axis_tuser;   // [2:0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [0] found, [32:1] read_value, [39:33] count
	logic [2:0]  m_axis_tuser;   // [2:0] status

	// Mirror of the table plus the queue of result beats still owed.
	class set_table_board;
		logic [31:0] mirror_entries [CAP];
		int          mirror_count;
		ust_res_t    pending_results [$];
		int          errors, n_results, n_full, n_swaps, peak;

		function new();
			mirror_count = 0;
			errors       = 0;
			n_results    = 0;
			n_full       = 0;
			n_swaps      = 0;
			peak         = 0;
		endfunction

		function int slot_of(logic [31:0] v);
			int p;
			for (p = 0; p < mirror_count; p++)
				if (mirror_entries[p] == v)
					return p;
			return -1;
		endfunction

		// accepted request beat: update the mirror, queue the expected result
		function void note_request(logic [2:0] fn, logic [31:0] val, logic [5:0] idx);
			ust_res_t r;
			int       pos;
			r   = '0;
			pos = slot_of(val);
			case (fn)
				FN_ADD: begin
					if (pos >= 0) begin
						r.status = ST_PRESENT;
						r.found  = 1'b1;
					end else if (mirror_count >= CAP) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						mirror_entries[mirror_count] = val;
						mirror_count++;
					end
				end
				FN_REMOVE: begin
					if (pos >= 0) begin
						r.found = 1'b1;
						mirror_count--;
						// hole filled from the tail
						if (pos < mirror_count) begin
							mirror_entries[pos] = mirror_entries[mirror_count];
							n_swaps++;
						end
					end else begin
						r.status = ST_ABSENT;
					end
				end
				FN_QUERY: begin
					if (pos >= 0)
						r.found = 1'b1;
					else
						r.status = ST_ABSENT;
				end
				FN_READ: begin
					if (int'(idx) < mirror_count)
						r.read_value = mirror_entries[idx];
					else
						r.status = ST_RANGE;
				end
				FN_CLEAR: begin
					mirror_count = 0;
				end
				default: ;
			endcase
			r.count = COUNT_W'(mirror_count);
			if (mirror_count > peak)
				peak = mirror_count;
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 60)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_result(ust_res_t got);
			ust_res_t want;
			n_results++;
			if (pending_results.size() == 0) begin
				report($sformatf("result beat %0d with nothing outstanding", n_results));
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("beat %0d status got %0d want %0d",
					n_results, got.status, want.status));
			if (got.found !== want.found)
				report($sformatf("beat %0d found got %0d want %0d",
					n_results, got.found, want.found));
			if (got.read_value !== want.read_value)
				report($sformatf("beat %0d read_value got %h want %h",
					n_results, got.read_value, want.read_value));
			if (got.count !== want.count)
				report($sformatf("beat %0d count got %0d want %0d",
					n_results, got.count, want.count));
		endtask
	endclass

	set_table_board board;
	logic [31:0]    value_pool [POOL_N];
	int             n_sent;
	int             tx_gap_pct;
	int             rx_stall_pct;

	unordered_int_set_table_unit #(
		.CAPACITY(CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#LIMIT_NS;
		$display("timeout with %0d results outstanding", board.pending_results.size());
		$display("tb_top: FAIL");
		$finish;
	end

	// Result side: random bursts of back-pressure.
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Values sampled before this edge's updates land, so no ordering race.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result({m_axis_tuser, m_axis_tdata[0], m_axis_tdata[32:1],
				m_axis_tdata[39:33]});
	end

	// One request beat; tvalid stays high into the next call unless a gap is drawn.
	task automatic send_request(logic [2:0] fn, logic [31:0] val, logic [5:0] idx);
		if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, idx, val};
		s_axis_tuser  <= fn;
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(fn, val, idx);
		n_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_results.size() > 0)
			@(posedge clk);
	endtask

	// Mix of fresh values, pool values (for repeats) and current members.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2:    return $urandom;
			3, 4, 5, 6: return value_pool[$urandom_range(0, POOL_N - 1)];
			default: begin
				if (board.mirror_count > 0)
					return board.mirror_entries[$urandom_range(0, board.mirror_count - 1)];
				return value_pool[$urandom_range(0, POOL_N - 1)];
			end
		endcase
	endfunction

	task automatic random_request();
		logic [2:0] fn;
		logic [5:0] idx;
		int         w;
		w   = $urandom_range(0, 99);
		idx = 6'($urandom_range(0, 63));
		if (w < 34)
			fn = FN_ADD;
		else if (w < 54)
			fn = FN_REMOVE;
		else if (w < 72)
			fn = FN_QUERY;
		else if (w < 92)
			fn = FN_READ;
		else if (w < 94)
			fn = FN_CLEAR;
		else
			fn = SPARE_FN[$urandom_range(0, 2)];
		// reads mostly land inside the occupied range
		if (fn == FN_READ && board.mirror_count > 0 && $urandom_range(0, 3) != 0)
			idx = 6'($urandom_range(0, board.mirror_count - 1));
		send_request(fn, pick_value(), idx);
	endtask

	// Fill to capacity, hit the full case, read around, then shrink the table mostly by removal.
	task automatic fill_and_drain();
		int n;
		while (board.mirror_count < CAP)
			send_request(FN_ADD, $urandom, 6'($urandom_range(0, 63)));
		repeat ($urandom_range(2, 4))
			send_request(FN_ADD, pick_value(), 6'($urandom_range(0, 63)));
		repeat ($urandom_range(4, 10))
			send_request(FN_READ, $urandom, 6'($urandom_range(0, 63)));
		n = $urandom_range(8, 64);
		repeat (n) begin
			if (board.mirror_count > 0 && $urandom_range(0, 4) != 0)
				send_request(FN_REMOVE,
					board.mirror_entries[$urandom_range(0, board.mirror_count - 1)],
					6'($urandom_range(0, 63)));
			else
				random_request();
		end
	endtask

	initial begin
		int  gap_levels [3];
		int  stall_levels [3];
		bit  first;
		int  i;
		gap_levels   = '{0, 10, 30};
		stall_levels = '{0, 5, 20};
		board        = new();
		n_sent       = 0;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= FN_ADD;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		value_pool[4] = 32'h0000_0001;
		for (i = 5; i < POOL_N; i++)
			value_pool[i] = $urandom;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, duplicates, swap removal
		send_request(FN_READ,   32'h0000_0000, 6'd0);   // empty: out of range
		send_request(FN_QUERY,  32'h0000_0000, 6'd0);
		send_request(FN_REMOVE, 32'h0000_0005, 6'd0);
		send_request(FN_ADD,    32'h8000_0000, 6'd0);
		send_request(FN_ADD,    32'h7FFF_FFFF, 6'd0);
		send_request(FN_ADD,    32'h0000_0000, 6'd0);
		send_request(FN_ADD,    32'hFFFF_FFFF, 6'd63);
		send_request(FN_ADD,    32'h8000_0000, 6'd0);   // already there
		send_request(FN_QUERY,  32'h7FFF_FFFF, 6'd0);
		send_request(FN_READ,   32'h0000_0000, 6'd0);
		send_request(FN_READ,   32'h0000_0000, 6'd3);
		send_request(FN_READ,   32'h0000_0000, 6'd4);   // one past the end
		send_request(FN_READ,   32'h0000_0000, 6'd63);
		send_request(FN_REMOVE, 32'h8000_0000, 6'd0);   // tail moves into slot 0
		send_request(FN_READ,   32'h0000_0000, 6'd0);
		send_request(FN_REMOVE, 32'hFFFF_FFFF, 6'd0);
		send_request(FN_QUERY,  32'hFFFF_FFFF, 6'd0);
		send_request(SPARE_FN[0], 32'hFFFF_FFFF, 6'd63);
		send_request(SPARE_FN[1], 32'h0000_0000, 6'd0);
		send_request(SPARE_FN[2], 32'h5555_5555, 6'd21);
		send_request(FN_CLEAR,  32'h0000_0000, 6'd0);
		send_request(FN_READ,   32'h0000_0000, 6'd0);
		send_request(FN_ADD,    32'h5555_5555, 6'd42);
		send_request(FN_ADD,    32'hAAAA_AAAA, 6'd21);
		send_request(FN_REMOVE, 32'h5555_5555, 6'd0);
		wait_drained();

		// random episodes; idling stops for the last stretch
		first = 1'b1;
		while (n_sent < N_ITEMS) begin
			if (n_sent >= N_ITEMS - CALM_TAIL) begin
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct   = gap_levels[$urandom_range(0, 2)];
				rx_stall_pct = stall_levels[$urandom_range(0, 2)];
			end
			if (first || $urandom_range(0, 5) == 0)
				fill_and_drain();
			else
				repeat ($urandom_range(30, 120)) random_request();
			first = 1'b0;
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYC) @(posedge clk);

		$display("ran %0d requests and %0d result beats, peak occupancy %0d",
			n_sent, board.n_results, board.peak);
		$display("adds refused on a full table %0d, swap removes %0d, mismatches %0d",
			board.n_full, board.n_swaps, board.errors);
		if (board.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
